/* sv/dshl_pkg.sv */
// Shared types, constants and the CRC-8 byte step for the daily step history logger.
// No dependencies; the top level and the bench import this package.
package dshl_pkg;

    // Default number of days kept in the history
    localparam int HISTORY_DAYS_DEF = 7;

    // Field widths fixed by the interface
    localparam int IDX_W      = 6;
    localparam int THR_W      = 17;
    localparam int YEAR_W     = 12;

    // Reset value of the save throttle register, in seconds
    localparam logic [THR_W-1:0]  THROTTLE_RESET = 17'd300;

    // Calendar base year; stored years are offsets from it
    localparam logic [YEAR_W-1:0] YEAR_BASE = 12'd1970;

    // CRC-8 generator polynomial and top-bit mask
    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_MSB  = 8'h80;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_NONE      = 2'd0,
        STAT_THROTTLED = 2'd1,
        STAT_ROLLOVER  = 2'd2,
        STAT_SAVE      = 2'd3
    } t_status;

    // Control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_PREP,
        ST_EMIT
    } t_state;

    // Fold one byte into a running CRC-8 (MSB first, no reflection)
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_MSB) != 8'd0) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

/* sv/daily_step_history_logger_top.sv */
// Top level of the daily step history logger: sequencer, state registers, record emitter.
// Depends on dshl_pkg and dshl_hist_ram.
//
//  channel   | direction | handshake                   | payload
//  ----------+-----------+-----------------------------+---------------------------------------
//  command   | in        | start, busy                 | i_op i_year i_month i_day
//            |           |                             | i_pedometer_count i_clock_seconds
//  result    | out       | o_strobe (one cycle each)   | o_status o_record_byte o_byte_index
//            |           |                             | o_ped_clear o_last
//  config    | in        | i_cfg_valid, o_cfg_ready    | i_cfg_data (save throttle seconds)
//
// An item that writes nothing, or a throttled save, holds busy high through the decide state and
// gives its single result in the following cycle. A write passes through the decide state and
// the prep (memory read) state, then sends one record byte per cycle, paced by the byte-serial
// CRC and the single history read port.
// Synchronous active-low reset empties the history and clears the control and architectural state; throttle is 300.
// The receiver cannot stall: every strobed result is taken in its cycle.
module daily_step_history_logger_top #(
    parameter int HISTORY_DAYS = dshl_pkg::HISTORY_DAYS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_op,
    input  logic [11:0] i_year,
    input  logic [3:0]  i_month,
    input  logic [4:0]  i_day,
    input  logic [31:0] i_pedometer_count,
    input  logic [31:0] i_clock_seconds,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [16:0] i_cfg_data,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [7:0]  o_record_byte,
    output logic [5:0]  o_byte_index,
    output logic        o_ped_clear,
    output logic        o_last
);
    import dshl_pkg::*;

    localparam int AW         = (HISTORY_DAYS > 1) ? $clog2(HISTORY_DAYS) : 1;
    localparam int CW         = $clog2(HISTORY_DAYS + 1);
    localparam int HIST_BYTES = 4 * HISTORY_DAYS;

    localparam logic [IDX_W-1:0] IDX_TODAY = IDX_W'(HIST_BYTES);
    localparam logic [IDX_W-1:0] IDX_COUNT = IDX_W'(HIST_BYTES + 4);
    localparam logic [IDX_W-1:0] IDX_YEAR  = IDX_W'(HIST_BYTES + 5);
    localparam logic [IDX_W-1:0] IDX_MONTH = IDX_W'(HIST_BYTES + 6);
    localparam logic [IDX_W-1:0] IDX_DAY   = IDX_W'(HIST_BYTES + 7);
    localparam logic [IDX_W-1:0] IDX_CRC   = IDX_W'(HIST_BYTES + 8);
    localparam logic [AW-1:0]    HEAD_LAST = AW'(HISTORY_DAYS - 1);
    localparam logic [CW-1:0]    COUNT_FULL = CW'(HISTORY_DAYS);
    localparam logic [AW:0]      DEPTH_W   = (AW + 1)'(HISTORY_DAYS);

    // Sequencer
    t_state r_state, n_state;

    // Latched command item
    logic              r_op, n_op;
    logic [11:0]       r_year, n_year;
    logic [3:0]        r_month, n_month;
    logic [4:0]        r_day, n_day;
    logic [31:0]       r_steps, n_steps;
    logic [31:0]       r_now, n_now;

    // Architectural state outside the history memory
    logic [AW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_hcount, n_hcount;
    logic [31:0]       r_today, n_today;
    logic [7:0]        r_sy, n_sy;
    logic [7:0]        r_sm, n_sm;
    logic [7:0]        r_sd, n_sd;
    logic [31:0]       r_last_save, n_last_save;
    logic [THR_W-1:0]  r_throttle;

    // Record emitter
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [7:0]        r_crc, n_crc;
    logic [31:0]       r_word, n_word;
    t_status           r_wstat, n_wstat;
    logic              r_pulse, n_pulse;

    // Result registers
    logic              r_strobe, n_strobe;
    t_status           r_o_status, n_o_status;
    logic [7:0]        r_o_byte, n_o_byte;
    logic [IDX_W-1:0]  r_o_index, n_o_index;
    logic              r_o_pr, n_o_pr;
    logic              r_o_last, n_o_last;

    // History memory port signals
    logic              mem_we;
    logic [AW-1:0]     mem_raddr;
    logic [31:0]       mem_rdata;

    // Decision terms
    logic [11:0]       year_ofs;
    logic [7:0]        year_st;
    logic              date_same, first_date, rollover, throttled;

    // Byte selection terms
    logic [3:0]        rd_word;
    logic [AW:0]       rd_sum;
    logic [31:0]       hist_word, sel_word, word_shift;
    logic [7:0]        cur_byte;

    dshl_hist_ram #(
        .DEPTH (HISTORY_DAYS),
        .AW    (AW)
    ) u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (r_head),
        .i_wdata (r_steps),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Classify the latched item
    always_comb begin
        year_ofs   = r_year - YEAR_BASE;
        year_st    = year_ofs[7:0];
        first_date = (r_sd == 8'd0);
        date_same  = (year_st == r_sy) && (8'(r_month) == r_sm) && (8'(r_day) == r_sd);
        rollover   = !r_op && !first_date && !date_same;
        throttled  = r_op && (r_last_save != 32'd0) && (r_now >= r_last_save)
                     && ((r_now - r_last_save) < 32'(r_throttle));
    end

    // Read the history oldest first: slot = head + word, wrapped at the depth
    always_comb begin
        rd_word   = (r_state == ST_PREP) ? 4'd0 : (r_idx[5:2] + 4'd1);
        rd_sum    = {1'b0, r_head} + (AW + 1)'(rd_word);
        if (rd_sum >= DEPTH_W) begin
            rd_sum = rd_sum - DEPTH_W;
        end
        mem_raddr = rd_sum[AW-1:0];
    end

    // Pick the record byte at the current index
    always_comb begin
        hist_word  = (r_idx[1:0] == 2'd0) ? mem_rdata : r_word;
        sel_word   = (r_idx < IDX_TODAY) ? hist_word : r_today;
        word_shift = sel_word >> {~r_idx[1:0], 3'b000};
        if (r_idx == IDX_COUNT) begin
            cur_byte = 8'(r_hcount);
        end else if (r_idx == IDX_YEAR) begin
            cur_byte = r_sy;
        end else if (r_idx == IDX_MONTH) begin
            cur_byte = r_sm;
        end else if (r_idx == IDX_DAY) begin
            cur_byte = r_sd;
        end else if (r_idx == IDX_CRC) begin
            cur_byte = r_crc;
        end else begin
            cur_byte = word_shift[7:0];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (rollover || (r_op && !throttled)) begin
                    n_state = ST_PREP;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_PREP: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (r_idx == IDX_CRC) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath and result values
    always_comb begin
        n_op        = r_op;
        n_year      = r_year;
        n_month     = r_month;
        n_day       = r_day;
        n_steps     = r_steps;
        n_now       = r_now;
        n_head      = r_head;
        n_hcount    = r_hcount;
        n_today     = r_today;
        n_sy        = r_sy;
        n_sm        = r_sm;
        n_sd        = r_sd;
        n_last_save = r_last_save;
        n_idx       = r_idx;
        n_crc       = r_crc;
        n_word      = r_word;
        n_wstat     = r_wstat;
        n_pulse     = r_pulse;
        n_strobe    = 1'b0;
        n_o_status  = STAT_NONE;
        n_o_byte    = 8'd0;
        n_o_index   = '0;
        n_o_pr      = 1'b0;
        n_o_last    = 1'b0;
        mem_we      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // Capture the command item
                if (start) begin
                    n_op    = i_op;
                    n_year  = i_year;
                    n_month = i_month;
                    n_day   = i_day;
                    n_steps = i_pedometer_count;
                    n_now   = i_clock_seconds;
                end
            end
            ST_DECIDE: begin
                if (!r_op) begin
                    // Tick: copy the count and record the date
                    n_today = r_steps;
                    n_sy    = year_st;
                    n_sm    = 8'(r_month);
                    n_sd    = 8'(r_day);
                    if (rollover) begin
                        // Push today into the oldest slot and advance the ring
                        mem_we      = 1'b1;
                        n_head      = (r_head == HEAD_LAST) ? '0 : r_head + AW'(1);
                        n_hcount    = (r_hcount == COUNT_FULL) ? r_hcount
                                                               : r_hcount + CW'(1);
                        n_today     = 32'd0;
                        n_last_save = 32'd0;
                        n_wstat     = STAT_ROLLOVER;
                        n_pulse     = 1'b1;
                    end else begin
                        n_strobe = 1'b1;
                        n_o_last = 1'b1;
                    end
                end else if (throttled) begin
                    // Drop the save without touching state
                    n_strobe   = 1'b1;
                    n_o_status = STAT_THROTTLED;
                    n_o_last   = 1'b1;
                end else begin
                    n_today     = r_steps;
                    n_last_save = r_now;
                    n_wstat     = STAT_SAVE;
                    n_pulse     = 1'b0;
                end
            end
            ST_PREP: begin
                // First history word is being read
                n_idx = '0;
                n_crc = 8'd0;
            end
            ST_EMIT: begin
                // Send one record byte and fold it into the CRC
                n_strobe   = 1'b1;
                n_o_status = r_wstat;
                n_o_byte   = cur_byte;
                n_o_index  = r_idx;
                n_o_pr     = r_pulse && (r_idx == '0);
                n_o_last   = (r_idx == IDX_CRC);
                n_crc      = crc8_byte(r_crc, cur_byte);
                n_idx      = r_idx + IDX_W'(1);
                if (r_idx[1:0] == 2'd0) begin
                    n_word = mem_rdata;
                end
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    // Control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_hcount    <= '0;
            r_today     <= 32'd0;
            r_sy        <= 8'd0;
            r_sm        <= 8'd0;
            r_sd        <= 8'd0;
            r_last_save <= 32'd0;
            r_throttle  <= THROTTLE_RESET;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_hcount    <= n_hcount;
            r_today     <= n_today;
            r_sy        <= n_sy;
            r_sm        <= n_sm;
            r_sd        <= n_sd;
            r_last_save <= n_last_save;
            r_strobe    <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                r_throttle <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_year     <= n_year;
        r_month    <= n_month;
        r_day      <= n_day;
        r_steps    <= n_steps;
        r_now      <= n_now;
        r_idx      <= n_idx;
        r_crc      <= n_crc;
        r_word     <= n_word;
        r_wstat    <= n_wstat;
        r_pulse    <= n_pulse;
        r_o_status <= n_o_status;
        r_o_byte   <= n_o_byte;
        r_o_index  <= n_o_index;
        r_o_pr     <= n_o_pr;
        r_o_last   <= n_o_last;
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_strobe      = r_strobe;
    assign o_status      = r_o_status;
    assign o_record_byte = r_o_byte;
    assign o_byte_index  = r_o_index;
    assign o_ped_clear   = r_o_pr;
    assign o_last        = r_o_last;

`ifndef NO_ASSERTIONS
    // A finished item is never followed directly by another result
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_strobe)
        else $error("result strobed right after a final result");

    // Record bytes come back to back with rising index
    a_record_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> (o_strobe && (o_byte_index == $past(o_byte_index) + 6'd1)))
        else $error("record byte stream broken");

    // Pedometer clear only on the first byte of a rollover record
    a_pr_first_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ped_clear |-> (o_strobe && (o_status == STAT_ROLLOVER) && (o_byte_index == 6'd0)))
        else $error("pedometer clear outside rollover first byte");

    // History fill count never passes the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hcount <= COUNT_FULL)
        else $error("history count overflow");
`endif

endmodule

/* sv/dshl_hist_ram.sv */
// Day history store: one write port, one registered read port, one valid bit per entry.
// Standalone module; entries never written read back as zero.
module dshl_hist_ram #(
    parameter int DEPTH = 7,
    parameter int AW    = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0]      mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [31:0]      r_rdata;

    // Write the entry; a read of it in the same cycle returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Mark entries that hold a real day
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    // Registered read; an unwritten entry reads as its reset value of zero
    always_ff @(posedge i_clk) begin
        r_rdata <= r_valid[i_raddr] ? mem[i_raddr] : 32'd0;
    end

    assign o_rdata = r_rdata;

endmodule

/* bench/tb_top.sv */
// Self-checking bench for daily_step_history_logger_top: ticks, rollovers, throttled saves.
// Depends on dshl_pkg and the block's RTL; predicts every record byte and checks it in order.
`timescale 1ns / 100ps

module tb_top;
    import dshl_pkg::*;

    localparam int DAYS       = HISTORY_DAYS_DEF;
    localparam int REC_LEN    = 4 * DAYS + 9;
    localparam int SETTLE_CYC = 4 * DAYS + 12;

    // Command codes carried on i_op
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SAVE = 1'b1;

    typedef enum {ENT_CMD, ENT_CFG, ENT_PAUSE} t_ent_kind;
    typedef enum {DRV_FETCH, DRV_GAP, DRV_OFFER, DRV_SETTLE, DRV_CFG, DRV_DONE} t_drv_state;

    typedef struct {
        t_ent_kind   kind;
        logic        op;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [31:0] steps;
        logic [31:0] secs;
        logic [16:0] thr;
        int unsigned gap;
    } t_item;

    typedef struct {
        t_status    status;
        logic [7:0] data;
        logic [5:0] idx;
        logic       pr;
        logic       fin;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_op = 1'b0;
    logic [11:0] i_year = '0;
    logic [3:0]  i_month = '0;
    logic [4:0]  i_day = '0;
    logic [31:0] i_pedometer_count = '0;
    logic [31:0] i_clock_seconds = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [16:0] i_cfg_data = '0;
    logic        o_strobe;
    logic [1:0]  o_status;
    logic [7:0]  o_record_byte;
    logic [5:0]  o_byte_index;
    logic        o_ped_clear;
    logic        o_last;

    daily_step_history_logger_top #(.HISTORY_DAYS(DAYS)) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_op              (i_op),
        .i_year            (i_year),
        .i_month           (i_month),
        .i_day             (i_day),
        .i_pedometer_count (i_pedometer_count),
        .i_clock_seconds   (i_clock_seconds),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .o_strobe          (o_strobe),
        .o_status          (o_status),
        .o_record_byte     (o_record_byte),
        .o_byte_index      (o_byte_index),
        .o_ped_clear       (o_ped_clear),
        .o_last            (o_last)
    );

    // Clock: 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_item       item_q[$];
    t_result     record_due_q[$];
    int unsigned err_cnt = 0;
    bit          burst = 1'b0;

    // Logger state as seen by the bench
    logic [31:0] hist_days[DAYS];
    logic [7:0]  hist_fill;
    logic [31:0] day_steps;
    logic [7:0]  date_y;
    logic [7:0]  date_m;
    logic [7:0]  date_d;
    logic [31:0] save_stamp;
    logic [16:0] throttle_s;

    // Driver bookkeeping
    t_drv_state  drv_st = DRV_FETCH;
    t_item       cur;
    int unsigned gap_left;
    int unsigned settle_cnt;

    // Fold one byte into the running CRC-8, one bit per shift
    function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc ^ b;
        repeat (8) begin
            fb = c[7];
            c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

    function automatic void push_result(input t_status st, input logic [7:0] d,
                                        input logic [5:0] ix, input logic pr,
                                        input logic fin);
        t_result r;
        r.status = st;
        r.data   = d;
        r.idx    = ix;
        r.pr     = pr;
        r.fin    = fin;
        record_due_q.push_back(r);
    endfunction

    // Serialize the current state into one record, CRC last
    function automatic void push_record(input t_status st, input logic pulse);
        logic [7:0] rec[REC_LEN];
        logic [7:0] crc;
        crc = 8'h00;
        for (int i = 0; i < DAYS; i++) begin
            {rec[4*i], rec[4*i+1], rec[4*i+2], rec[4*i+3]} = hist_days[i];
        end
        {rec[4*DAYS], rec[4*DAYS+1], rec[4*DAYS+2], rec[4*DAYS+3]} = day_steps;
        rec[4*DAYS+4] = hist_fill;
        rec[4*DAYS+5] = date_y;
        rec[4*DAYS+6] = date_m;
        rec[4*DAYS+7] = date_d;
        for (int i = 0; i < REC_LEN - 1; i++) begin
            crc = crc_fold(crc, rec[i]);
        end
        rec[REC_LEN-1] = crc;
        for (int i = 0; i < REC_LEN; i++) begin
            push_result(st, rec[i], 6'(i), pulse && (i == 0), i == REC_LEN - 1);
        end
    endfunction

    // Advance the logger state by one accepted item and queue its results
    function automatic void apply_logger_item(input t_item it);
        logic [7:0]  y;
        logic [31:0] elapsed;
        logic [11:0] yoff;
        yoff = it.year - YEAR_BASE;
        y    = yoff[7:0];
        if (it.op == OP_TICK) begin
            day_steps = it.steps;
            if (date_d == 8'd0) begin
                date_y = y;
                date_m = {4'd0, it.month};
                date_d = {3'd0, it.day};
                push_result(STAT_NONE, 8'd0, 6'd0, 1'b0, 1'b1);
            end else if (y == date_y && {4'd0, it.month} == date_m
                         && {3'd0, it.day} == date_d) begin
                push_result(STAT_NONE, 8'd0, 6'd0, 1'b0, 1'b1);
            end else begin
                for (int i = 0; i < DAYS - 1; i++) begin
                    hist_days[i] = hist_days[i+1];
                end
                hist_days[DAYS-1] = day_steps;
                if (hist_fill < 8'(DAYS)) begin
                    hist_fill = hist_fill + 8'd1;
                end
                date_y      = y;
                date_m      = {4'd0, it.month};
                date_d      = {3'd0, it.day};
                day_steps   = '0;
                push_record(STAT_ROLLOVER, 1'b1);
                save_stamp  = '0;
            end
        end else begin
            elapsed = (it.secs >= save_stamp) ? it.secs - save_stamp : 32'(throttle_s);
            if (save_stamp != 0 && elapsed < 32'(throttle_s)) begin
                push_result(STAT_THROTTLED, 8'd0, 6'd0, 1'b0, 1'b1);
            end else begin
                day_steps   = it.steps;
                save_stamp  = it.secs;
                push_record(STAT_SAVE, 1'b0);
            end
        end
    endfunction

    // Present the current item and raise start
    task automatic offer_item();
        i_op              <= cur.op;
        i_year            <= cur.year;
        i_month           <= cur.month;
        i_day             <= cur.day;
        i_pedometer_count <= cur.steps;
        i_clock_seconds   <= cur.secs;
        start             <= 1'b1;
        drv_st            = DRV_OFFER;
    endtask

    // Fetch the next entry; start gets exactly one assignment here
    task automatic take_next();
        if (item_q.size() == 0) begin
            start  <= 1'b0;
            drv_st = DRV_DONE;
        end else begin
            cur = item_q.pop_front();
            if (cur.kind == ENT_CMD && cur.gap == 0) begin
                offer_item();
            end else if (cur.kind == ENT_CMD) begin
                start    <= 1'b0;
                gap_left = cur.gap;
                drv_st   = DRV_GAP;
            end else begin
                start      <= 1'b0;
                settle_cnt = 0;
                drv_st     = DRV_SETTLE;
            end
        end
    endtask

    // Driver: offer items, pause for drains, write the throttle while idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start       <= 1'b0;
            i_cfg_valid <= 1'b0;
            drv_st      = DRV_FETCH;
        end else begin
            case (drv_st)
                DRV_FETCH: begin
                    take_next();
                end
                DRV_GAP: begin
                    gap_left = gap_left - 1;
                    if (gap_left == 0) begin
                        offer_item();
                    end
                end
                DRV_OFFER: begin
                    if (!busy) begin
                        apply_logger_item(cur);
                        take_next();
                    end
                end
                DRV_SETTLE: begin
                    if (record_due_q.size() != 0 || busy) begin
                        settle_cnt = 0;
                    end else begin
                        settle_cnt = settle_cnt + 1;
                        if (settle_cnt >= SETTLE_CYC) begin
                            if (cur.kind == ENT_CFG) begin
                                i_cfg_valid <= 1'b1;
                                i_cfg_data  <= cur.thr;
                                drv_st      = DRV_CFG;
                            end else begin
                                take_next();
                            end
                        end
                    end
                end
                DRV_CFG: begin
                    if (o_cfg_ready) begin
                        throttle_s  = cur.thr;
                        i_cfg_valid <= 1'b0;
                        take_next();
                    end
                end
                default: begin
                end
            endcase
        end
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            err_cnt++;
        end
    endfunction

    // Monitor: take every strobed result and compare with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (record_due_q.size() == 0) begin
                $error("result with no expectation: status %0d byte %0d index %0d",
                       o_status, o_record_byte, o_byte_index);
                err_cnt++;
            end else begin
                want = record_due_q.pop_front();
                check_field("status", want.status, o_status);
                check_field("record_byte", want.data, o_record_byte);
                check_field("byte_index", want.idx, o_byte_index);
                check_field("ped_clear", want.pr, o_ped_clear);
                check_field("last", want.fin, o_last);
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (burst || r < 45) begin
            return 0;
        end else if (r < 80) begin
            return $urandom_range(1, 4);
        end else if (r < 94) begin
            return $urandom_range(5, 45);
        end
        return $urandom_range(46, 120);
    endfunction

    function automatic void push_cmd(input logic op, input logic [11:0] y,
                                     input logic [3:0] m, input logic [4:0] d,
                                     input logic [31:0] steps, input logic [31:0] secs);
        t_item it;
        it.kind  = ENT_CMD;
        it.op    = op;
        it.year  = y;
        it.month = m;
        it.day   = d;
        it.steps = steps;
        it.secs  = secs;
        it.thr   = '0;
        it.gap   = pick_gap();
        item_q.push_back(it);
    endfunction

    function automatic void push_ctrl(input t_ent_kind kind, input logic [16:0] thr);
        t_item it;
        it.kind  = kind;
        it.op    = 1'b0;
        it.year  = '0;
        it.month = '0;
        it.day   = '0;
        it.steps = '0;
        it.secs  = '0;
        it.thr   = thr;
        it.gap   = 0;
        item_q.push_back(it);
    endfunction

    // Give up after a generous fixed time
    initial begin
        #5_000_000;
        $display("FAIL daily_step_history_logger_top");
        $finish;
    end

    // Stimulus: directed cases, then random phases over several throttle settings
    initial begin : stim
        logic [16:0] thr_pick[6];
        logic [16:0] gen_thr;
        logic [31:0] gclk;
        logic [11:0] gy;
        logic [3:0]  gm;
        logic [4:0]  gd;
        int unsigned r;
        int unsigned sel;

        // Logger state after reset
        for (int i = 0; i < DAYS; i++) begin
            hist_days[i] = '0;
        end
        hist_fill   = '0;
        day_steps   = '0;
        date_y      = '0;
        date_m      = '0;
        date_d      = '0;
        save_stamp  = '0;
        throttle_s  = THROTTLE_RESET;

        // Saves at the reset throttle: first, inside window, edge, backwards, clock zero
        push_cmd(OP_SAVE, 12'd0, 4'd0, 5'd0, 32'hFFFF_FFFF, 32'd1000);
        push_cmd(OP_SAVE, 12'd0, 4'd0, 5'd0, 32'd1, 32'd1100);
        push_cmd(OP_SAVE, 12'd0, 4'd0, 5'd0, 32'd2, 32'd1299);
        push_cmd(OP_SAVE, 12'd0, 4'd0, 5'd0, 32'd3, 32'd1300);
        push_cmd(OP_SAVE, 12'd0, 4'd0, 5'd0, 32'd4, 32'd500);
        push_cmd(OP_SAVE, 12'd0, 4'd0, 5'd0, 32'd5, 32'd0);
        push_cmd(OP_SAVE, 12'd0, 4'd0, 5'd0, 32'd6, 32'd10);
        // Ticks: first date, same date, rollover, save after rollover
        push_cmd(OP_TICK, 12'd1970, 4'd1, 5'd1, 32'd0, 32'd0);
        push_cmd(OP_TICK, 12'd1970, 4'd1, 5'd1, 32'd12345, 32'hFFFF_FFFF);
        push_cmd(OP_TICK, 12'd2225, 4'd12, 5'd31, 32'hFFFF_FFFF, 32'd0);
        push_cmd(OP_SAVE, 12'd0, 4'd0, 5'd0, 32'd5, 32'd20);
        // Day zero, then a tick that counts as first date again, then a wrapped year
        push_cmd(OP_TICK, 12'd4095, 4'd15, 5'd0, 32'h5555_5555, 32'd0);
        push_cmd(OP_TICK, 12'd0, 4'd0, 5'd31, 32'hAAAA_AAAA, 32'd0);
        push_cmd(OP_TICK, 12'd1969, 4'd15, 5'd31, 32'h0000_FFFF, 32'd0);
        // Overfill the history
        for (int d = 1; d <= DAYS + 1; d++) begin
            push_cmd(OP_TICK, 12'd2000, 4'd6, 5'(d), $urandom, $urandom);
        end
        // Save ignores the date fields; then a backwards clock
        push_cmd(OP_SAVE, 12'd4095, 4'd15, 5'd31, 32'h5555_5555, 32'hFFFF_FFFF);
        push_cmd(OP_SAVE, 12'd4095, 4'd15, 5'd31, 32'hAAAA_AAAA, 32'hFFFF_FFFE);
        // Smallest throttle, then zero throttle
        push_ctrl(ENT_CFG, 17'd1);
        push_cmd(OP_SAVE, 12'd0, 4'd0, 5'd0, 32'd7, 32'd100);
        push_cmd(OP_SAVE, 12'd0, 4'd0, 5'd0, 32'd8, 32'd100);
        push_cmd(OP_SAVE, 12'd0, 4'd0, 5'd0, 32'd9, 32'd101);
        push_ctrl(ENT_CFG, 17'd0);
        push_cmd(OP_SAVE, 12'd0, 4'd0, 5'd0, 32'd10, 32'd5);
        push_cmd(OP_SAVE, 12'd0, 4'd0, 5'd0, 32'd11, 32'd5);

        // Random phases: mostly coherent days and paced saves, some noise
        thr_pick = '{17'd1, 17'd86400, 17'd300, 17'h1FFFF, 17'd0, 17'd60};
        gy = 12'd2024;
        gm = 4'd3;
        gd = 5'd1;
        gclk = $urandom;
        for (int ph = 0; ph < 10; ph++) begin
            gen_thr = (ph < 6) ? thr_pick[ph] : 17'($urandom_range(1, 86400));
            push_ctrl(ENT_CFG, gen_thr);
            burst = (ph % 4 == 3);
            for (int n = 0; n < 40; n++) begin
                r = $urandom_range(0, 99);
                if (r < 30) begin
                    push_cmd(OP_TICK, gy, gm, gd, $urandom, $urandom);
                end else if (r < 45) begin
                    if ($urandom_range(0, 9) == 0) begin
                        gy = 12'($urandom_range(1970, 2225));
                        gm = 4'($urandom_range(1, 12));
                        gd = 5'($urandom_range(1, 31));
                    end else if (gd >= 5'd28) begin
                        gd = 5'd1;
                        gm = (gm >= 4'd12) ? 4'd1 : gm + 4'd1;
                    end else begin
                        gd = gd + 5'd1;
                    end
                    push_cmd(OP_TICK, gy, gm, gd, $urandom, $urandom);
                end else if (r < 80) begin
                    sel = $urandom_range(0, 5);
                    case (sel)
                        0: gclk = gclk + 32'(gen_thr) - 32'd1;
                        1: gclk = gclk + 32'(gen_thr);
                        2: gclk = gclk + 32'(gen_thr) + 32'd1;
                        3: gclk = gclk + 32'($urandom_range(0, 3));
                        default: gclk = gclk + 32'($urandom_range(0, 2 * gen_thr + 2));
                    endcase
                    push_cmd(OP_SAVE, 12'($urandom_range(0, 4095)), 4'($urandom_range(0, 15)),
                             5'($urandom_range(0, 31)), $urandom, gclk);
                end else begin
                    sel = $urandom_range(0, 3);
                    case (sel)
                        0: push_cmd(OP_SAVE, 12'd0, 4'd0, 5'd0, $urandom, 32'd0);
                        1: push_cmd(OP_SAVE, 12'd0, 4'd0, 5'd0, $urandom,
                                    gclk - 32'($urandom_range(1, 1000)));
                        2: push_cmd(OP_TICK, gy, gm, 5'd0, $urandom, $urandom);
                        default: push_cmd(1'($urandom_range(0, 1)),
                                          12'($urandom_range(0, 4095)),
                                          4'($urandom_range(0, 15)),
                                          5'($urandom_range(0, 31)), $urandom, $urandom);
                    endcase
                end
            end
            // Hold the sender until all results are in
            if (ph % 3 == 1) begin
                push_ctrl(ENT_PAUSE, 17'd0);
            end
        end

        // Hold reset, once, then release it
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain and finish
        @(posedge i_clk);
        while (drv_st != DRV_DONE || record_due_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("PASS daily_step_history_logger_top");
        end else begin
            $display("FAIL daily_step_history_logger_top");
        end
        $finish;
    end

endmodule

/* files.f */
sv/dshl_pkg.sv
sv/dshl_hist_ram.sv
sv/daily_step_history_logger_top.sv
bench/tb_top.sv
